@@ rtl/core/energy_vad_hysteresis_assert.svh @@
// Assertion macros shared by the voice activity detector RTL.
`ifndef ENERGY_VAD_HYSTERESIS_ASSERT_SVH
`define ENERGY_VAD_HYSTERESIS_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define EVH_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("energy_vad_hysteresis: check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define EVH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("energy_vad_hysteresis: check failed");

`endif

@@ rtl/core/evh_pkg.sv @@
// Shared widths, codes and types for the voice activity detector.
package evh_pkg;

   localparam int SAMPLE_W     = 16;
   localparam int MAG_W        = SAMPLE_W + 1;
   localparam int THRESH_W     = 16;
   localparam int FRAMES_W     = 8;
   localparam int CSR_DATA_W   = 16;
   localparam int CSR_INDEX_W  = 2;
   localparam int MAX_FRAME_SAMPLES = 1024;
   localparam int TALLY_W      = $clog2(MAX_FRAME_SAMPLES + 1);
   localparam int SUM_W        = $clog2(MAX_FRAME_SAMPLES * (1 << SAMPLE_W - 1) + 1);
   localparam int BOUND_W      = (THRESH_W + 1) + TALLY_W;

   localparam logic [THRESH_W-1:0] THRESH_RESET  = THRESH_W'(819);
   localparam logic [FRAMES_W-1:0] TRIGGER_RESET = FRAMES_W'(3);
   localparam logic [FRAMES_W-1:0] RELEASE_RESET = FRAMES_W'(10);
   localparam logic [FRAMES_W-1:0] COUNT_MAX     = '1;

   typedef enum logic [1:0] {
      DEC_SILENCE  = 2'd0,
      DEC_SPEECH   = 2'd1,
      DEC_HANGOVER = 2'd2
   } dec_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_TRIGGER   = 2'd1,
      CSR_RELEASE   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [FRAMES_W-1:0] trigger_frames;
      logic [FRAMES_W-1:0] release_frames;
   } hang_cfg_type;

   typedef struct packed {
      logic close;
      logic loud;
   } frame_status_type;

endpackage

@@ rtl/core/evh_accum.sv @@
// Per-frame magnitude accumulator and loudness compare.
module evh_accum (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [evh_pkg::SAMPLE_W-1:0]  sample,
   input  logic                          frame_end,
   input  logic [evh_pkg::THRESH_W-1:0]  threshold_level,
   output evh_pkg::frame_status_type     status
);
   import evh_pkg::*;

   logic [SUM_W-1:0]    sum_ff,   sum_in;
   logic [TALLY_W-1:0]  tally_ff, tally_in;
   logic [MAG_W-1:0]    mag;
   logic                room;
   logic [SUM_W-1:0]    sum_next;
   logic [TALLY_W-1:0]  tally_next;
   logic [THRESH_W:0]   level_plus;
   logic [BOUND_W-1:0]  bound;

   // Take the magnitude; the most negative sample maps to 2^15
   always_comb begin
      if (sample[SAMPLE_W-1]) begin
         mag = MAG_W'(0) - {1'b1, sample};
      end else begin
         mag = {1'b0, sample};
      end
   end

   // Add the sample unless the frame is already full
   assign room       = (tally_ff < TALLY_W'(MAX_FRAME_SAMPLES));
   assign sum_next   = room ? (sum_ff + SUM_W'(mag)) : sum_ff;
   assign tally_next = room ? (tally_ff + TALLY_W'(1)) : tally_ff;

   // floor(sum / n) > T  is the same as  sum >= (T + 1) * n
   assign level_plus  = {1'b0, threshold_level} + (THRESH_W + 1)'(1);
   assign bound       = BOUND_W'(level_plus) * BOUND_W'(tally_next);
   assign status.loud  = (BOUND_W'(sum_next) >= bound);
   assign status.close = step && frame_end;

   // Advance the running sums; clear them when the frame closes
   always_comb begin
      sum_in   = sum_ff;
      tally_in = tally_ff;
      if (step) begin
         if (frame_end) begin
            sum_in   = '0;
            tally_in = '0;
         end else begin
            sum_in   = sum_next;
            tally_in = tally_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         tally_ff <= '0;
      end else begin
         sum_ff   <= sum_in;
         tally_ff <= tally_in;
      end
   end

endmodule

@@ rtl/core/evh_hangover.sv @@
// Loud/quiet frame counters and speech state with hangover.
module evh_hangover (
   input  logic                        clock,
   input  logic                        reset,
   input  evh_pkg::frame_status_type   status,
   input  evh_pkg::hang_cfg_type       cfg,
   output evh_pkg::dec_type            decision
);
   import evh_pkg::*;

   logic [FRAMES_W-1:0] loud_ff,   loud_in;
   logic [FRAMES_W-1:0] quiet_ff,  quiet_in;
   logic                speech_ff, speech_in;
   logic [FRAMES_W-1:0] loud_inc,  quiet_inc;

   // Saturating increments
   assign loud_inc  = (loud_ff  == COUNT_MAX) ? loud_ff  : loud_ff  + FRAMES_W'(1);
   assign quiet_inc = (quiet_ff == COUNT_MAX) ? quiet_ff : quiet_ff + FRAMES_W'(1);

   // Update counters and speech state on a closed frame
   always_comb begin
      loud_in   = loud_ff;
      quiet_in  = quiet_ff;
      speech_in = speech_ff;
      decision  = speech_ff ? DEC_SPEECH : DEC_HANGOVER;
      if (status.loud) begin
         loud_in  = loud_inc;
         quiet_in = '0;
         if (!speech_ff && (loud_inc >= cfg.trigger_frames)) begin
            speech_in = 1'b1;
         end
         decision = speech_in ? DEC_SPEECH : DEC_HANGOVER;
      end else begin
         quiet_in = quiet_inc;
         if (speech_ff && (quiet_inc >= cfg.release_frames)) begin
            speech_in = 1'b0;
            loud_in   = '0;
            decision  = DEC_SILENCE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loud_ff   <= '0;
         quiet_ff  <= '0;
         speech_ff <= 1'b0;
      end else if (status.close) begin
         loud_ff   <= loud_in;
         quiet_ff  <= quiet_in;
         speech_ff <= speech_in;
      end
   end

endmodule

@@ rtl/core/energy_vad_hysteresis.sv @@
// Energy voice activity detector with hangover: top level.
//
// Usage:
//   req_* carries one signed 16-bit audio sample per beat; req_frame_end
//   marks the last sample of a frame. rsp_* carries one decision beat per
//   frame: rsp_decision (0 released to silence, 1 speech, 2 not in speech)
//   and rsp_frame_loud. csr_* writes threshold_level (index 0),
//   trigger_frames (1) and release_frames (2); write only while idle.
// Timing:
//   A sample beat is held in the input register, then summed; the decision
//   for a frame is loaded into the result register and shows on rsp_valid.
//   One sample per cycle is taken while no held decision stalls a closing
//   sample; accumulate and (T+1)*n compare in evh_accum are combinational.
// Reset:
//   Synchronous, active high. Clears the frame sums, frame counters and
//   speech state, and loads threshold 819, trigger 3 and release 10.
// Backpressure:
//   While rsp_stall holds a decision, samples that do not close a frame
//   keep flowing; a frame-closing sample waits in the input register and
//   req_stall rises until the held decision is taken.
`include "energy_vad_hysteresis_assert.svh"

module energy_vad_hysteresis (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [evh_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                              req_frame_end,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_decision,
   output logic                              rsp_frame_loud,
   input  logic                              csr_we,
   input  logic [evh_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [evh_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import evh_pkg::*;

   logic [THRESH_W-1:0] thresh_ff;
   logic [FRAMES_W-1:0] trigger_ff;
   logic [FRAMES_W-1:0] release_ff;

   logic                s1_valid_ff, s1_valid_in;
   logic [SAMPLE_W-1:0] s1_sample_ff;
   logic                s1_end_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   dec_type             rsp_dec_ff;
   logic                rsp_loud_ff;

   logic                req_take;
   logic                out_free;
   logic                s1_go;
   frame_status_type    status;
   hang_cfg_type        hang_cfg;
   dec_type             decision;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff  <= THRESH_RESET;
         trigger_ff <= TRIGGER_RESET;
         release_ff <= RELEASE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_THRESHOLD: thresh_ff  <= csr_wdata[THRESH_W-1:0];
            CSR_TRIGGER:   trigger_ff <= csr_wdata[FRAMES_W-1:0];
            CSR_RELEASE:   release_ff <= csr_wdata[FRAMES_W-1:0];
            default: ;
         endcase
      end
   end

   // Handshake: a frame-closing beat needs a free result slot
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_go     = s1_valid_ff && (!s1_end_ff || out_free);
   assign req_stall = s1_valid_ff && !s1_go;
   assign req_take  = req_valid && !req_stall;

   // Input register
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_sample_ff <= req_sample;
         s1_end_ff    <= req_frame_end;
      end
   end

   evh_accum u_accum (
      .clock           (clock),
      .reset           (reset),
      .step            (s1_go),
      .sample          (s1_sample_ff),
      .frame_end       (s1_end_ff),
      .threshold_level (thresh_ff),
      .status          (status)
   );

   assign hang_cfg.trigger_frames = trigger_ff;
   assign hang_cfg.release_frames = release_ff;

   evh_hangover u_hangover (
      .clock    (clock),
      .reset    (reset),
      .status   (status),
      .cfg      (hang_cfg),
      .decision (decision)
   );

   // Result register: load on a closed frame, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (status.close) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (status.close) begin
         rsp_dec_ff  <= decision;
         rsp_loud_ff <= status.loud;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_decision   = rsp_dec_ff;
   assign rsp_frame_loud = rsp_loud_ff;

   // Release to silence only happens on a quiet frame
   `EVH_ASSERT_NOW(a_silence_quiet, clock, reset,
      rsp_valid && (rsp_decision == DEC_SILENCE), !rsp_frame_loud)
   // Samples that do not close a frame never block the input
   `EVH_ASSERT_NOW(a_mid_frame_flows, clock, reset,
      s1_valid_ff && !s1_end_ff, !req_stall)
   // A held decision blocks the next frame-closing beat
   `EVH_ASSERT_NOW(a_close_waits, clock, reset,
      s1_valid_ff && s1_end_ff && rsp_valid && rsp_stall, req_stall && !status.close)
   // A closed frame always shows up as a result beat
   `EVH_ASSERT_NEXT(a_close_shows, clock, reset, status.close, rsp_valid)

endmodule

@@ bench/vad_frame_checker.sv @@
// Scoreboard for the voice activity detector: frame predictor and decision compare.
module vad_frame_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic signed [evh_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                req_frame_end,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [1:0]                          rsp_decision,
   input  logic                                rsp_frame_loud,
   input  logic                                csr_we,
   input  logic [evh_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [evh_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output int                                  mismatch_count,
   output int                                  decisions_pending,
   output int                                  decisions_seen,
   output int                                  loud_seen,
   output int                                  releases_seen
);
   import evh_pkg::*;

   typedef struct packed {
      dec_type decision;
      logic    loud;
   } frame_verdict_type;

   // Shadow copies of the registers and of the frame state
   logic [THRESH_W-1:0] level_limit;
   logic [FRAMES_W-1:0] enter_count;
   logic [FRAMES_W-1:0] leave_count;
   logic [SUM_W-1:0]    mag_total;
   logic [TALLY_W-1:0]  mag_samples;
   logic [FRAMES_W-1:0] loud_run;
   logic [FRAMES_W-1:0] quiet_run;
   logic                talking;

   frame_verdict_type frame_verdicts[$];

   // Close the frame: mean, loud test, hangover counters, decision
   function automatic frame_verdict_type judge_frame();
      frame_verdict_type v;
      logic [SUM_W-1:0]  mean;
      logic              released;
      mean     = mag_total / mag_samples;
      v.loud   = (mean > level_limit);
      released = 1'b0;
      mag_total   = '0;
      mag_samples = '0;
      if (v.loud) begin
         if (loud_run != COUNT_MAX) loud_run = loud_run + 1'b1;
         quiet_run = '0;
         if (!talking && loud_run >= enter_count) talking = 1'b1;
      end else begin
         if (quiet_run != COUNT_MAX) quiet_run = quiet_run + 1'b1;
         if (talking && quiet_run >= leave_count) begin
            talking  = 1'b0;
            loud_run = '0;
            released = 1'b1;
         end
      end
      if (released) v.decision = DEC_SILENCE;
      else if (talking) v.decision = DEC_SPEECH;
      else v.decision = DEC_HANGOVER;
      return v;
   endfunction

   // Sample at the falling edge: the handshake that completes at the next
   // rising edge is stable by then
   always @(negedge clock) begin
      logic [MAG_W-1:0]  mag;
      frame_verdict_type want;
      if (reset) begin
         level_limit = THRESH_RESET;
         enter_count = TRIGGER_RESET;
         leave_count = RELEASE_RESET;
         mag_total   = '0;
         mag_samples = '0;
         loud_run    = '0;
         quiet_run   = '0;
         talking     = 1'b0;
         frame_verdicts.delete();
         mismatch_count = 0;
         decisions_seen = 0;
         loud_seen      = 0;
         releases_seen  = 0;
      end else begin
         // Track register writes
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_THRESHOLD: level_limit = csr_wdata[THRESH_W-1:0];
               CSR_TRIGGER:   enter_count = csr_wdata[FRAMES_W-1:0];
               CSR_RELEASE:   leave_count = csr_wdata[FRAMES_W-1:0];
               default: ;
            endcase
         end

         // Accumulate the sample beat; drop samples past the frame cap
         if (req_valid && !req_stall) begin
            mag = req_sample[SAMPLE_W-1] ? MAG_W'(-$signed({1'b1, req_sample}))
                                         : MAG_W'(req_sample);
            if (mag_samples < MAX_FRAME_SAMPLES) begin
               mag_total   = mag_total + mag;
               mag_samples = mag_samples + 1'b1;
            end
            if (req_frame_end) frame_verdicts.push_back(judge_frame());
         end

         // Compare the decision beat with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            decisions_seen++;
            if (frame_verdicts.size() == 0) begin
               mismatch_count++;
               $error("decision beat with no frame pending: decision %0d, frame_loud %0d",
                      rsp_decision, rsp_frame_loud);
            end else begin
               want = frame_verdicts.pop_front();
               if (want.loud) loud_seen++;
               if (want.decision == DEC_SILENCE) releases_seen++;
               if (rsp_decision !== want.decision) begin
                  mismatch_count++;
                  $error("decision: expected %0d, got %0d", want.decision, rsp_decision);
               end
               if (rsp_frame_loud !== want.loud) begin
                  mismatch_count++;
                  $error("frame_loud: expected %0d, got %0d", want.loud, rsp_frame_loud);
               end
            end
         end
      end
      decisions_pending = frame_verdicts.size();
   end

endmodule

@@ bench/tb_energy_vad_hysteresis.sv @@
// Testbench top for the voice activity detector: stimulus, idling and verdict.
module tb_energy_vad_hysteresis;
   import evh_pkg::*;

   typedef enum {KIND_LOUD, KIND_QUIET, KIND_EDGE, KIND_NOISE} frame_kind_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic                       req_frame_end = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [1:0]                 rsp_decision;
   logic                       rsp_frame_loud;
   logic                       csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_wdata = '0;

   int mismatch_count;
   int decisions_pending;
   int decisions_seen;
   int loud_seen;
   int releases_seen;

   bit gaps_on = 1'b1;
   int beats_sent = 0;
   int level_now = 819;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   energy_vad_hysteresis u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample     (req_sample),
      .req_frame_end  (req_frame_end),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_decision   (rsp_decision),
      .rsp_frame_loud (rsp_frame_loud),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   vad_frame_checker u_frame_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample        (req_sample),
      .req_frame_end     (req_frame_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_decision      (rsp_decision),
      .rsp_frame_loud    (rsp_frame_loud),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .mismatch_count    (mismatch_count),
      .decisions_pending (decisions_pending),
      .decisions_seen    (decisions_seen),
      .loud_seen         (loud_seen),
      .releases_seen     (releases_seen)
   );

   // Stall the decision side at random while gaps are on
   always @(posedge clock) begin
      rsp_stall <= gaps_on ? ($urandom_range(99) < 30) : 1'b0;
   end

   // Offer one sample beat and hold it until taken
   task automatic send_beat(input logic signed [SAMPLE_W-1:0] s, input logic fe);
      logic stalled;
      while (gaps_on && $urandom_range(99) < 30) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample    <= s;
      req_frame_end <= fe;
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled);
      beats_sent++;
   endtask

   // Magnitude to a sample of random sign; 32768 and up give the most negative
   function automatic logic signed [SAMPLE_W-1:0] signed_sample(input int mag);
      if (mag >= 32768) return 16'sh8000;
      return $urandom_range(1) ? SAMPLE_W'(-mag) : SAMPLE_W'(mag);
   endfunction

   // Send one frame: magnitudes above, below or near the threshold, or noise
   task automatic send_frame(input int len, input frame_kind_type kind);
      int mag;
      logic signed [SAMPLE_W-1:0] s;
      for (int i = 0; i < len; i++) begin
         case (kind)
            KIND_LOUD:  mag = (level_now >= 32768) ? $urandom_range(32768, 0)
                                                   : $urandom_range(32768, level_now + 1);
            KIND_QUIET: mag = $urandom_range((level_now > 32768) ? 32768 : level_now, 0);
            KIND_EDGE: begin
               mag = level_now - 1 + $urandom_range(3);
               if (mag < 0) mag = 0;
               if (mag > 32768) mag = 32768;
            end
            default: mag = 0;
         endcase
         s = (kind == KIND_NOISE) ? SAMPLE_W'($urandom()) : signed_sample(mag);
         send_beat(s, i == len - 1);
      end
   endtask

   // Drop valid, wait for every decision (with a limit), then let the pipe settle
   task automatic drain();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (decisions_pending != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
   endtask

   // Write all three registers on consecutive cycles
   task automatic write_regs(input int level, input int trig, input int rel);
      csr_we    <= 1'b1;
      csr_index <= CSR_THRESHOLD;
      csr_wdata <= CSR_DATA_W'(level);
      @(posedge clock);
      csr_index <= CSR_TRIGGER;
      csr_wdata <= CSR_DATA_W'(trig);
      @(posedge clock);
      csr_index <= CSR_RELEASE;
      csr_wdata <= CSR_DATA_W'(rel);
      @(posedge clock);
      csr_we    <= 1'b0;
      level_now  = level;
   endtask

   // One register setting, then alternating runs of loud and quiet frames
   task automatic run_phase(input int level, input int trig, input int rel, input int budget,
                            input int max_len, input int min_run, input int max_run,
                            input bit mixed);
      int start;
      int run;
      int r;
      bit loud_turn;
      frame_kind_type kind;
      drain();
      write_regs(level, trig, rel);
      start = beats_sent;
      loud_turn = $urandom_range(1);
      while (beats_sent - start < budget) begin
         run = $urandom_range(max_run, min_run);
         repeat (run) begin
            r = mixed ? $urandom_range(99) : 0;
            if (r < 75) kind = loud_turn ? KIND_LOUD : KIND_QUIET;
            else if (r < 90) kind = KIND_EDGE;
            else kind = KIND_NOISE;
            send_frame($urandom_range(max_len, 1), kind);
         end
         loud_turn = !loud_turn;
      end
   endtask

   // Overlong frame: the samples past the cap would flip the loud call
   task automatic send_overlong(input bit loud);
      for (int i = 0; i < MAX_FRAME_SAMPLES; i++)
         send_beat(signed_sample(loud ? level_now + 1 : $urandom_range(level_now, level_now - 50)),
                   1'b0);
      repeat (2) send_beat(loud ? 16'sh0000 : 16'sh8000, 1'b0);
      send_beat(loud ? 16'sh0000 : 16'sh8000, 1'b1);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed frames at the reset settings
      send_beat(16'sh8000, 1'b1);   // most negative sample alone: loud
      send_beat(16'sh7fff, 1'b1);   // positive full scale: loud
      send_beat(16'sh0000, 1'b1);   // quiet frame keeps the loud count
      send_beat(-16'sd820, 1'b1);   // third loud frame enters speech
      send_beat(16'sd819, 1'b0);    // mean truncates to the threshold: quiet
      send_beat(-16'sd820, 1'b1);
      send_beat(16'sh8000, 1'b0);   // mixed frame, loud, clears the quiet count
      send_beat(16'sh7fff, 1'b0);
      send_beat(16'sh0000, 1'b0);
      send_beat(-16'sd1, 1'b0);
      send_beat(16'sd1, 1'b1);
      repeat (10) send_beat(16'sd819, 1'b1);   // ten quiet frames release speech

      // Random phases over several settings, extremes first
      run_phase(0, 0, 0, 16, 3, 1, 3, 1'b1);
      run_phase(32768, 255, 255, 12, 3, 1, 3, 1'b1);
      run_phase(819, 3, 10, 40, 2, 3, 12, 1'b1);
      repeat (2)
         run_phase($urandom_range(32768, 0), $urandom_range(4, 0), $urandom_range(6, 0),
                   16, 3, 1, 6, 1'b1);
      run_phase(32767, 1, 0, 12, 3, 1, 4, 1'b1);

      // Overlong frame, no idling on either side
      drain();
      write_regs(16000, 2, 1);
      gaps_on = 1'b0;
      send_overlong(1'b0);
      gaps_on = 1'b1;

      drain();
      repeat (10) @(posedge clock);

      if (decisions_pending != 0)
         $error("%0d frame decisions never arrived", decisions_pending);
      $display("tb_energy_vad_hysteresis: %0d sample beats sent, %0d frame decisions checked",
               beats_sent, decisions_seen);
      $display("tb_energy_vad_hysteresis: %0d loud frames, %0d releases to silence",
               loud_seen, releases_seen);
      if (mismatch_count == 0 && decisions_pending == 0)
         $display("tb_energy_vad_hysteresis: PASS");
      else
         $display("tb_energy_vad_hysteresis: FAIL");
      $finish;
   end

   // Hard stop if the run hangs
   initial begin
      #4000000;
      $display("tb_energy_vad_hysteresis: FAIL");
      $finish;
   end

endmodule
